// ===== rtl/periodic_timer_table_assert.svh =====
// Assertion macros used by the timer table checker.
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PTT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptt_pkg.sv =====
// Package of the periodic timer table: field widths, opcodes, status codes and types.
package ptt_pkg;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 6;
    localparam int PERIOD_W = 24;
    localparam int REP_W    = 16;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 64;

    // Command opcodes; code 7 is a no-op
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL     = 3'd2;
    localparam logic [OP_W-1:0] OP_SET     = 3'd3;
    localparam logic [OP_W-1:0] OP_SUSPEND = 3'd4;
    localparam logic [OP_W-1:0] OP_RESUME  = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // One timer entry as held in the memory
    typedef struct packed {
        logic                forever_flag;
        logic [PERIOD_W-1:0] period;
        logic [REP_W-1:0]    remaining;
        logic [TICK_W-1:0]   last_fire;
    } t_entry;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TICK = 5'b00010,
        S_ADD  = 5'b00100,
        S_RMW  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

// ===== rtl/ptt_cmd_if.sv =====
// Command channel of the periodic timer table.
interface ptt_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::OP_W-1:0]      opcode;
    logic [ptt_pkg::SLOT_W-1:0]    slot;
    logic [ptt_pkg::PERIOD_W-1:0]  period;
    logic [ptt_pkg::REP_W-1:0]     repeats;
    logic                          forever_req;
    logic                          has_action;

    modport source (
        output valid, opcode, slot, period, repeats, forever_req, has_action,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot, period, repeats, forever_req, has_action,
        output ready
    );
endinterface

// ===== rtl/ptt_res_if.sv =====
// Result channel of the periodic timer table.
interface ptt_res_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::STATUS_W-1:0]  status;
    logic [ptt_pkg::SLOT_W-1:0]    slot_taken;
    logic [ptt_pkg::MASK_W-1:0]    fired_mask;

    modport source (
        output valid, status, slot_taken, fired_mask,
        input  ready
    );
    modport sink (
        input  valid, status, slot_taken, fired_mask,
        output ready
    );
endinterface

// ===== rtl/periodic_timer_table.sv =====
// Periodic timer table.
// A tick walks the timer memory one entry per cycle (read, then write-back of a fired entry);
// an add walks the valid bits one per cycle to find the lowest free slot.
// One command at a time: a new command is taken only once the last result has entered the output
// register, which waits while the sink holds it off.
// Sync active-low reset clears tick counter, flags and sequencer; timer memory is not cleared.
module periodic_timer_table #(
    parameter int NUM_TIMERS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptt_cmd_if.sink     i_cmd,
    ptt_res_if.source   o_res
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int XW = 10;  // wide enough to compare any index against 64 or NUM_TIMERS

    // Sequencer and counters
    ptt_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt;
    logic [ptt_pkg::TICK_W-1:0] r_now;

    // Per-slot flags in flip-flops
    logic [NUM_TIMERS-1:0] r_valid;
    logic [NUM_TIMERS-1:0] r_susp;
    logic [NUM_TIMERS-1:0] r_act;

    // Timer memory and its read port
    ptt_pkg::t_entry r_mem [NUM_TIMERS];
    ptt_pkg::t_entry r_rd;
    logic [IW-1:0]   r_eidx;
    logic            r_rd_v;

    // Latched command payload for add
    logic [ptt_pkg::PERIOD_W-1:0] r_period;
    logic [ptt_pkg::REP_W-1:0]    r_repeats;
    logic                         r_forever;
    logic                         r_action;

    // Result under construction and output register
    logic [ptt_pkg::STATUS_W-1:0] r_status;
    logic [ptt_pkg::SLOT_W-1:0]   r_taken;
    logic [ptt_pkg::MASK_W-1:0]   r_mask;
    logic                         r_o_valid;
    logic [ptt_pkg::STATUS_W-1:0] r_o_status;
    logic [ptt_pkg::SLOT_W-1:0]   r_o_taken;
    logic [ptt_pkg::MASK_W-1:0]   r_o_mask;

    logic                    in_acc;
    logic [XW-1:0]           slot_x;
    logic [IW-1:0]           slot_idx;
    logic                    found;
    logic                    needs_slot;
    logic [IW-1:0]           cnt_idx;
    logic [XW-1:0]           cnt_idx_x;
    logic                    cnt_end;
    logic                    add_hit;
    logic [XW-1:0]           eidx_x;
    logic [ptt_pkg::TICK_W-1:0] elapsed;
    logic                    fire;
    logic                    out_free;
    logic                    rd_en;
    logic [IW-1:0]           rd_addr;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    ptt_pkg::t_entry         wr_data;

    assign i_cmd.ready = (r_state == ptt_pkg::S_IDLE);
    assign in_acc      = i_cmd.valid && i_cmd.ready;

    // Addressed slot lookup
    assign slot_x   = {{(XW-ptt_pkg::SLOT_W){1'b0}}, i_cmd.slot};
    assign slot_idx = slot_x[IW-1:0];
    assign found    = (slot_x < XW'(NUM_TIMERS)) && r_valid[slot_idx];
    assign needs_slot = (i_cmd.opcode == ptt_pkg::OP_DEL) || (i_cmd.opcode == ptt_pkg::OP_SET) ||
                        (i_cmd.opcode == ptt_pkg::OP_SUSPEND) ||
                        (i_cmd.opcode == ptt_pkg::OP_RESUME);

    // Scan counter shared by tick and add
    assign cnt_idx   = r_cnt[IW-1:0];
    assign cnt_idx_x = {{(XW-IW){1'b0}}, cnt_idx};
    assign cnt_end   = (r_cnt == CW'(NUM_TIMERS));
    assign add_hit   = (r_state == ptt_pkg::S_ADD) && !cnt_end && !r_valid[cnt_idx];

    // Fire check on the entry read last cycle
    assign eidx_x  = {{(XW-IW){1'b0}}, r_eidx};
    assign elapsed = r_now - r_rd.last_fire;
    assign fire = (r_state == ptt_pkg::S_TICK) && r_rd_v &&
                  r_valid[r_eidx] && !r_susp[r_eidx] && r_act[r_eidx] &&
                  (r_rd.period != '0) && (r_rd.forever_flag || (r_rd.remaining != '0)) &&
                  (elapsed >= {{(ptt_pkg::TICK_W-ptt_pkg::PERIOD_W){1'b0}}, r_rd.period});

    assign out_free = !r_o_valid || o_res.ready;

    // Memory read port: tick scan or resume read-modify-write
    assign rd_en = ((r_state == ptt_pkg::S_TICK) && !cnt_end) ||
                   (in_acc && (i_cmd.opcode == ptt_pkg::OP_RESUME) && found);
    assign rd_addr = (r_state == ptt_pkg::S_TICK) ? cnt_idx : slot_idx;

    // Memory write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_eidx;
        wr_data = r_rd;
        priority if (in_acc && (i_cmd.opcode == ptt_pkg::OP_SET) && found) begin
            wr_en   = 1'b1;
            wr_addr = slot_idx;
            wr_data = '{forever_flag: i_cmd.forever_req, period: i_cmd.period,
                        remaining: i_cmd.repeats, last_fire: r_now};
        end else if (add_hit) begin
            wr_en   = 1'b1;
            wr_addr = cnt_idx;
            wr_data = '{forever_flag: r_forever, period: r_period,
                        remaining: r_repeats, last_fire: r_now};
        end else if (fire) begin
            wr_en   = 1'b1;
            wr_data.last_fire = r_now;
            if (!r_rd.forever_flag) begin
                wr_data.remaining = r_rd.remaining - 1'b1;
            end
        end else if (r_state == ptt_pkg::S_RMW) begin
            wr_en   = 1'b1;
            wr_data.last_fire = r_now;
        end else begin
            wr_en   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd   <= r_mem[rd_addr];
            r_eidx <= rd_addr;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptt_pkg::S_IDLE: begin
                if (in_acc) begin
                    priority if (i_cmd.opcode == ptt_pkg::OP_TICK) begin
                        n_state = ptt_pkg::S_TICK;
                    end else if (i_cmd.opcode == ptt_pkg::OP_ADD) begin
                        n_state = ptt_pkg::S_ADD;
                    end else if ((i_cmd.opcode == ptt_pkg::OP_RESUME) && found) begin
                        n_state = ptt_pkg::S_RMW;
                    end else begin
                        n_state = ptt_pkg::S_DONE;
                    end
                end
            end
            ptt_pkg::S_TICK: if (cnt_end) n_state = ptt_pkg::S_DONE;
            ptt_pkg::S_ADD:  if (cnt_end || add_hit) n_state = ptt_pkg::S_DONE;
            ptt_pkg::S_RMW:  n_state = ptt_pkg::S_DONE;
            ptt_pkg::S_DONE: if (out_free) n_state = ptt_pkg::S_IDLE;
            default:         n_state = ptt_pkg::S_IDLE;
        endcase
    end

    // Control state, flags and tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ptt_pkg::S_IDLE;
            r_cnt     <= '0;
            r_now     <= '0;
            r_valid   <= '0;
            r_susp    <= '0;
            r_act     <= '0;
            r_rd_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == ptt_pkg::S_TICK) && !cnt_end;

            if (in_acc) begin
                r_cnt <= '0;
                if (i_cmd.opcode == ptt_pkg::OP_TICK) begin
                    r_now <= r_now + 1'b1;
                end
                if (i_cmd.opcode == ptt_pkg::OP_CLEAR) begin
                    r_valid <= '0;
                end
                if (found) begin
                    if (i_cmd.opcode == ptt_pkg::OP_DEL)     r_valid[slot_idx] <= 1'b0;
                    if (i_cmd.opcode == ptt_pkg::OP_SET)     r_act[slot_idx]   <= i_cmd.has_action;
                    if (i_cmd.opcode == ptt_pkg::OP_SUSPEND) r_susp[slot_idx]  <= 1'b1;
                    if (i_cmd.opcode == ptt_pkg::OP_RESUME)  r_susp[slot_idx]  <= 1'b0;
                end
            end else if (((r_state == ptt_pkg::S_TICK) || (r_state == ptt_pkg::S_ADD)) &&
                         !cnt_end) begin
                r_cnt <= r_cnt + 1'b1;
            end

            // Allocation by add
            if (add_hit) begin
                r_valid[cnt_idx] <= 1'b1;
                r_susp[cnt_idx]  <= 1'b0;
                r_act[cnt_idx]   <= r_action;
            end

            // Output register handshake
            if ((r_state == ptt_pkg::S_DONE) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload: latched command, result under construction, output register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_period  <= i_cmd.period;
            r_repeats <= i_cmd.repeats;
            r_forever <= i_cmd.forever_req;
            r_action  <= i_cmd.has_action;
            r_status  <= (needs_slot && !found) ? ptt_pkg::ST_NOTFOUND : ptt_pkg::ST_OK;
            r_taken   <= '0;
            r_mask    <= '0;
        end
        if ((r_state == ptt_pkg::S_ADD) && cnt_end) begin
            r_status <= ptt_pkg::ST_FULL;
        end
        if (add_hit) begin
            r_taken <= cnt_idx_x[ptt_pkg::SLOT_W-1:0];
        end
        if (fire && (eidx_x < XW'(ptt_pkg::MASK_W))) begin
            r_mask[eidx_x[ptt_pkg::SLOT_W-1:0]] <= 1'b1;
        end
        if ((r_state == ptt_pkg::S_DONE) && out_free) begin
            r_o_status <= r_status;
            r_o_taken  <= r_taken;
            r_o_mask   <= r_mask;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.status     = r_o_status;
    assign o_res.slot_taken = r_o_taken;
    assign o_res.fired_mask = r_o_mask;

endmodule

// ===== rtl/ptt_checker.sv =====
// Port-level checker for the periodic timer table and its bind.
`include "periodic_timer_table_assert.svh"

module ptt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ptt_pkg::STATUS_W-1:0]  i_status,
    input logic [ptt_pkg::SLOT_W-1:0]    i_slot_taken,
    input logic [ptt_pkg::MASK_W-1:0]    i_fired_mask
);

    // A stalled result holds
    `PTT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_slot_taken) && $stable(i_fired_mask), "result changed while stalled")

    // One command in work: no transfer right after a transfer
    `PTT_ASSERT_NEXT(a_one_cmd, i_in_valid && i_in_ready, !i_in_ready, "command taken while busy")

    // Fired slots only come with a clean tick result
    `PTT_ASSERT_SAME(a_mask_ok, i_out_valid && (i_fired_mask != '0), (i_status == ptt_pkg::ST_OK) && (i_slot_taken == '0), "fired mask on non-tick result")

    // An allocated slot is reported only with status ok
    `PTT_ASSERT_SAME(a_taken_ok, i_out_valid && (i_slot_taken != '0), i_status == ptt_pkg::ST_OK, "slot reported without ok status")

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_slot_taken (o_res.slot_taken),
    .i_fired_mask (o_res.fired_mask)
);

// ===== sim/tb_top.sv =====
// Testbench for the periodic timer table: directed table, then random command sequences.
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_SLOTS    = 64;
    localparam int CLK_PERIOD   = 4;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = NUM_SLOTS + 16;
    localparam int HOLD_START   = 3000;
    localparam int HOLD_CYCLES  = 400;

    // Opcode 7 has no name in the package; the block treats it as a no-op
    localparam logic [ptt_pkg::OP_W-1:0] OP_NOP = 3'd7;

    typedef struct packed {
        logic [ptt_pkg::OP_W-1:0]     opcode;
        logic [ptt_pkg::SLOT_W-1:0]   slot;
        logic [ptt_pkg::PERIOD_W-1:0] period;
        logic [ptt_pkg::REP_W-1:0]    repeats;
        logic                         forever_req;
        logic                         has_action;
    } t_timer_cmd;

    typedef struct packed {
        logic [ptt_pkg::STATUS_W-1:0] status;
        logic [ptt_pkg::SLOT_W-1:0]   slot_taken;
        logic [ptt_pkg::MASK_W-1:0]   fired_mask;
    } t_timer_result;

    // typed = 1: the result is written in the row, else it comes from the predictor
    typedef struct packed {
        t_timer_cmd    cmd;
        logic          typed;
        t_timer_result want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ptt_cmd_if cmd_if ();
    ptt_res_if res_if ();

    periodic_timer_table #(
        .NUM_TIMERS (NUM_SLOTS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the timer table
    logic [ptt_pkg::TICK_W-1:0]   tick_count    = '0;
    logic [NUM_SLOTS-1:0]         tmr_valid     = '0;
    logic [NUM_SLOTS-1:0]         tmr_suspended = '0;
    logic [NUM_SLOTS-1:0]         tmr_action    = '0;
    logic [NUM_SLOTS-1:0]         tmr_forever   = '0;
    logic [ptt_pkg::PERIOD_W-1:0] tmr_period    [NUM_SLOTS] = '{default: '0};
    logic [ptt_pkg::REP_W-1:0]    tmr_remaining [NUM_SLOTS] = '{default: '0};
    logic [ptt_pkg::TICK_W-1:0]   tmr_last_fire [NUM_SLOTS] = '{default: '0};

    t_timer_result pending_results[$];
    int            mismatch_count = 0;
    logic          hold_off = 1'b0;

    // Side info that travels with the command payload
    logic          cmd_typed;
    t_timer_result cmd_typed_res;

    t_directed_row dir_rows [24] = '{
        '{'{ptt_pkg::OP_TICK,    6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_DEL,     6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_NOTFOUND, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_SET,     6'd63, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1,
            '{ptt_pkg::ST_NOTFOUND, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_SUSPEND, 6'd5,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_NOTFOUND, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_RESUME,  6'd63, 24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_NOTFOUND, 6'd0, 64'd0}},
        '{'{OP_NOP,              6'd63, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_ADD,     6'd0,  24'd1,      16'd2,    1'b0, 1'b1}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_ADD,     6'd0,  24'd2,      16'd0,    1'b1, 1'b1}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd1, 64'd0}},
        '{'{ptt_pkg::OP_ADD,     6'd0,  24'd1,      16'd5,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd2, 64'd0}},
        '{'{ptt_pkg::OP_ADD,     6'd0,  24'd0,      16'd5,    1'b1, 1'b1}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd3, 64'd0}},
        '{'{ptt_pkg::OP_ADD,     6'd0,  24'hFFFFFF, 16'hFFFF, 1'b0, 1'b1}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd4, 64'd0}},
        '{'{ptt_pkg::OP_TICK,    6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{ptt_pkg::OP_TICK,    6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{ptt_pkg::OP_TICK,    6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{ptt_pkg::OP_SUSPEND, 6'd1,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_TICK,    6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{ptt_pkg::OP_RESUME,  6'd1,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_SET,     6'd0,  24'd1,      16'd0,    1'b0, 1'b1}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_TICK,    6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{ptt_pkg::OP_DEL,     6'd2,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_ADD,     6'd0,  24'd3,      16'd1,    1'b1, 1'b1}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd2, 64'd0}},
        '{'{ptt_pkg::OP_CLEAR,   6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_TICK,    6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_OK, 6'd0, 64'd0}},
        '{'{ptt_pkg::OP_DEL,     6'd0,  24'd0,      16'd0,    1'b0, 1'b0}, 1'b1,
            '{ptt_pkg::ST_NOTFOUND, 6'd0, 64'd0}}
    };

    // Write a timer entry from an add or set command; restamps with the current tick
    function automatic void load_timer(int s, t_timer_cmd c);
        tmr_action[s]    = c.has_action;
        tmr_forever[s]   = c.forever_req;
        tmr_period[s]    = c.period;
        tmr_remaining[s] = c.repeats;
        tmr_last_fire[s] = tick_count;
    endfunction

    // Apply one command to the shadow table and return the result it produces
    function automatic t_timer_result timer_table_step(t_timer_cmd c);
        t_timer_result              r;
        logic [ptt_pkg::TICK_W-1:0] elapsed;
        logic                       found;
        r     = '0;
        found = tmr_valid[c.slot];
        case (c.opcode)
            ptt_pkg::OP_TICK: begin
                tick_count = tick_count + 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    elapsed = tick_count - tmr_last_fire[i];
                    if (tmr_valid[i] && !tmr_suspended[i] && tmr_action[i] &&
                        tmr_period[i] != '0 && (tmr_forever[i] || tmr_remaining[i] != '0) &&
                        elapsed >= ptt_pkg::TICK_W'(tmr_period[i])) begin
                        tmr_last_fire[i] = tick_count;
                        if (!tmr_forever[i])
                            tmr_remaining[i] = tmr_remaining[i] - 1'b1;
                        r.fired_mask[i] = 1'b1;
                    end
                end
            end
            ptt_pkg::OP_ADD: begin
                // lowest free slot wins
                r.status = ptt_pkg::ST_FULL;
                for (int i = 0; i < NUM_SLOTS && r.status == ptt_pkg::ST_FULL; i++) begin
                    if (!tmr_valid[i]) begin
                        tmr_valid[i]     = 1'b1;
                        tmr_suspended[i] = 1'b0;
                        load_timer(i, c);
                        r.status     = ptt_pkg::ST_OK;
                        r.slot_taken = ptt_pkg::SLOT_W'(i);
                    end
                end
            end
            ptt_pkg::OP_DEL: begin
                if (found) tmr_valid[c.slot] = 1'b0;
                else r.status = ptt_pkg::ST_NOTFOUND;
            end
            ptt_pkg::OP_SET: begin
                if (found) load_timer(c.slot, c);
                else r.status = ptt_pkg::ST_NOTFOUND;
            end
            ptt_pkg::OP_SUSPEND: begin
                if (found) tmr_suspended[c.slot] = 1'b1;
                else r.status = ptt_pkg::ST_NOTFOUND;
            end
            ptt_pkg::OP_RESUME: begin
                if (found) begin
                    tmr_suspended[c.slot] = 1'b0;
                    tmr_last_fire[c.slot] = tick_count;
                end else begin
                    r.status = ptt_pkg::ST_NOTFOUND;
                end
            end
            ptt_pkg::OP_CLEAR: begin
                tmr_valid = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random command of a given opcode; timing fields kept small most of the time
    function automatic t_timer_cmd random_cmd(logic [ptt_pkg::OP_W-1:0] op);
        t_timer_cmd c;
        c.opcode      = op;
        c.slot        = ptt_pkg::SLOT_W'($urandom);
        c.period      = ptt_pkg::PERIOD_W'($urandom);
        c.repeats     = ptt_pkg::REP_W'($urandom);
        c.forever_req = 1'($urandom);
        c.has_action  = ($urandom_range(0, 99) < 85);
        if (op == ptt_pkg::OP_ADD || op == ptt_pkg::OP_SET) begin
            if ($urandom_range(0, 99) < 85)
                c.period = ptt_pkg::PERIOD_W'($urandom_range(0, 6));
            if ($urandom_range(0, 99) < 85)
                c.repeats = ptt_pkg::REP_W'($urandom_range(0, 4));
            c.forever_req = ($urandom_range(0, 99) < 30);
        end
        // slot ops mostly hit a live timer: walk up from a random start
        if (op inside {ptt_pkg::OP_DEL, ptt_pkg::OP_SET, ptt_pkg::OP_SUSPEND,
                       ptt_pkg::OP_RESUME} && tmr_valid != '0 &&
            $urandom_range(0, 99) < 80) begin
            for (int k = 0; k < NUM_SLOTS && !tmr_valid[c.slot]; k++)
                c.slot = c.slot + 1'b1;
        end
        return c;
    endfunction

    task automatic flag_mismatch(string what, logic [ptt_pkg::MASK_W-1:0] want,
                                 logic [ptt_pkg::MASK_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
    endtask

    // Offer one command and hold it until the transfer completes
    task automatic issue_cmd(t_timer_cmd c, logic typed, t_timer_result want);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.opcode      <= c.opcode;
        cmd_if.slot        <= c.slot;
        cmd_if.period      <= c.period;
        cmd_if.repeats     <= c.repeats;
        cmd_if.forever_req <= c.forever_req;
        cmd_if.has_action  <= c.has_action;
        cmd_typed          <= typed;
        cmd_typed_res      <= want;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    // Reset, directed table, random sequences, drain and verdict
    initial begin : stimulus
        int sent;
        int pick;
        int n;
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.opcode      = ptt_pkg::OP_TICK;
        cmd_if.slot        = '0;
        cmd_if.period      = '0;
        cmd_if.repeats     = '0;
        cmd_if.forever_req = 1'b0;
        cmd_if.has_action  = 1'b0;
        cmd_typed          = 1'b0;
        cmd_typed_res      = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            issue_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (sent == 0 || pick < 2) begin
                // fill the whole table, then push it past full
                if ($urandom_range(0, 1)) begin
                    issue_cmd(random_cmd(ptt_pkg::OP_CLEAR), 1'b0, '0);
                    sent++;
                end
                n = NUM_SLOTS + $urandom_range(1, 3);
                repeat (n) issue_cmd(random_cmd(ptt_pkg::OP_ADD), 1'b0, '0);
                sent += n;
            end else if (pick < 40) begin
                n = $urandom_range(1, 8);
                repeat (n) issue_cmd(random_cmd(ptt_pkg::OP_TICK), 1'b0, '0);
                sent += n;
            end else if (pick < 62) begin
                issue_cmd(random_cmd(ptt_pkg::OP_ADD), 1'b0, '0);
                sent++;
            end else if (pick < 90) begin
                issue_cmd(random_cmd(ptt_pkg::OP_W'($urandom_range(ptt_pkg::OP_DEL,
                                                                   ptt_pkg::OP_RESUME))),
                          1'b0, '0);
                sent++;
            end else if (pick < 93) begin
                issue_cmd(random_cmd(ptt_pkg::OP_CLEAR), 1'b0, '0);
                sent++;
            end else if (pick < 96) begin
                issue_cmd(random_cmd(OP_NOP), 1'b0, '0);
                sent++;
            end else begin
                issue_cmd(random_cmd(ptt_pkg::OP_W'($urandom)), 1'b0, '0);
                sent++;
            end
        end

        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Result side: ready runs and random idle stretches
    initial begin : result_sink
        int n;
        res_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = $urandom_range(1, 30);
            repeat (n) begin
                res_if.ready <= !hold_off;
                @(posedge i_clk);
            end
            n = idle_gap();
            if (n > 0) begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // One long receiver stall so the block backs up onto the command side
    initial begin : backpressure
        @(posedge i_clk iff i_rst_n);
        repeat (HOLD_START) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Command transfer: run the predictor and queue the expected result
    always @(posedge i_clk) begin : cmd_monitor
        t_timer_cmd    c;
        t_timer_result r;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            c.opcode      = cmd_if.opcode;
            c.slot        = cmd_if.slot;
            c.period      = cmd_if.period;
            c.repeats     = cmd_if.repeats;
            c.forever_req = cmd_if.forever_req;
            c.has_action  = cmd_if.has_action;
            r = timer_table_step(c);
            pending_results.push_back(cmd_typed ? cmd_typed_res : r);
        end
    end

    // Result transfer: compare against the oldest expectation
    always @(posedge i_clk) begin : res_monitor
        t_timer_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, fired_mask", '0, res_if.fired_mask);
            end else begin
                want = pending_results.pop_front();
                if (res_if.status !== want.status)
                    flag_mismatch("status", ptt_pkg::MASK_W'(want.status),
                                  ptt_pkg::MASK_W'(res_if.status));
                if (res_if.slot_taken !== want.slot_taken)
                    flag_mismatch("slot_taken", ptt_pkg::MASK_W'(want.slot_taken),
                                  ptt_pkg::MASK_W'(res_if.slot_taken));
                if (res_if.fired_mask !== want.fired_mask)
                    flag_mismatch("fired_mask", want.fired_mask, res_if.fired_mask);
            end
        end
    end

    // Hard stop well past the slowest legal run
    initial begin : watchdog
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_cmd_if.sv
rtl/ptt_res_if.sv
rtl/periodic_timer_table.sv
rtl/ptt_checker.sv
sim/tb_top.sv
